### design/trajectory_rmse_max_error_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory error core
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_RMSE_MAX_ERROR_CORE_MACROS_SVH
`define TRAJECTORY_RMSE_MAX_ERROR_CORE_MACROS_SVH

// check a plain property on every edge out of reset
`define TRMSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define TRMSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/trmse_pkg.sv
// ----------------------------------------------------------------------------
// trmse_pkg
// Types, widths and state codes shared by the trajectory error core.
// ----------------------------------------------------------------------------
`default_nettype none

package trmse_pkg;

  localparam int unsigned CoordW            = 24;
  localparam int unsigned DiffW             = 25;
  localparam int unsigned SqW               = 49;
  localparam int unsigned NormW             = 52;
  localparam int unsigned SumW              = 64;
  localparam int unsigned CntW              = 15;
  localparam int unsigned RmseW             = 24;
  localparam int unsigned TotW              = 25;
  localparam int unsigned OutCntW           = 13;
  localparam int unsigned RootW             = 32;
  localparam int unsigned SremW             = 34;
  localparam int unsigned IterW             = 6;
  localparam int unsigned AccW              = 50;
  localparam int unsigned MaxSamplesDefault = 4096;

  typedef struct packed {
    logic signed [CoordW-1:0] ref_x;
    logic signed [CoordW-1:0] ref_y;
    logic signed [CoordW-1:0] ref_z;
    logic signed [CoordW-1:0] rep_x;
    logic signed [CoordW-1:0] rep_y;
    logic signed [CoordW-1:0] rep_z;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [RmseW-1:0]   rmse_x;
    logic [RmseW-1:0]   rmse_y;
    logic [RmseW-1:0]   rmse_z;
    logic [TotW-1:0]    rmse_total;
    logic [TotW-1:0]    max_dist;
    logic [OutCntW-1:0] sample_count;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [SumW-1:0]  sum_x;
    logic [SumW-1:0]  sum_y;
    logic [SumW-1:0]  sum_z;
    logic [NormW-1:0] max_sq;
    logic [CntW-1:0]  count;
    logic             too_many;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDiv,
    BkSqrtAx,
    BkMul,
    BkAcc,
    BkSqrtTot,
    BkSqrtMax,
    BkOut
  } back_state_e;

endpackage

`default_nettype wire

### design/trmse_fifo.sv
// ----------------------------------------------------------------------------
// trmse_fifo
// Two-entry queue of trajectory snapshots between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module trmse_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire trmse_pkg::snap_t data_i,
  input  wire logic             pop_i,
  output trmse_pkg::snap_t      data_o,
  output trmse_pkg::q_stat_t    stat_o
);

  trmse_pkg::snap_t mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rptr_q];

endmodule

`default_nettype wire

### design/trmse_front.sv
// ----------------------------------------------------------------------------
// trmse_front
// Squares the axis differences of each pair and accumulates sums, maximum
// squared norm and count; hands a snapshot to the queue on the last pair.
// ----------------------------------------------------------------------------
`default_nettype none

module trmse_front #(
  parameter int unsigned MaxSamples = trmse_pkg::MaxSamplesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire trmse_pkg::in_item_t in_data_i,
  input  wire trmse_pkg::q_stat_t  q_stat_i,
  output logic                     q_push_o,
  output trmse_pkg::snap_t         q_data_o
);

  localparam int unsigned SqW   = trmse_pkg::SqW;
  localparam int unsigned SumW  = trmse_pkg::SumW;
  localparam int unsigned NormW = trmse_pkg::NormW;
  localparam int unsigned CntW  = trmse_pkg::CntW;
  localparam int unsigned DiffW = trmse_pkg::DiffW;

  logic signed [DiffW-1:0]   dx, dy, dz;
  logic signed [2*DiffW-1:0] px, py, pz;
  logic                      accept, s1_adv;

  logic                      s1_valid_q;
  logic                      s1_last_q;
  logic [SqW-1:0]            sqx_q, sqy_q, sqz_q;

  logic [SumW-1:0]           sum_x_q, sum_y_q, sum_z_q;
  logic [NormW-1:0]          max_q;
  logic [CntW-1:0]           cnt_q;
  logic                      tm_q;

  logic [SumW:0]             ax, ay, az;
  logic [NormW-1:0]          norm;
  logic                      room;
  trmse_pkg::snap_t          nx;

  assign dx = $signed({in_data_i.rep_x[23], in_data_i.rep_x})
            - $signed({in_data_i.ref_x[23], in_data_i.ref_x});
  assign dy = $signed({in_data_i.rep_y[23], in_data_i.rep_y})
            - $signed({in_data_i.ref_y[23], in_data_i.ref_y});
  assign dz = $signed({in_data_i.rep_z[23], in_data_i.rep_z})
            - $signed({in_data_i.ref_z[23], in_data_i.ref_z});
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign s1_adv = s1_valid_q && (!s1_last_q || !q_stat_i.full);
  assign full   = s1_valid_q && !s1_adv;
  assign accept = push && !full;

  always_comb begin
    ax   = {1'b0, sum_x_q} + {{(SumW+1-SqW){1'b0}}, sqx_q};
    ay   = {1'b0, sum_y_q} + {{(SumW+1-SqW){1'b0}}, sqy_q};
    az   = {1'b0, sum_z_q} + {{(SumW+1-SqW){1'b0}}, sqz_q};
    norm = {{(NormW-SqW){1'b0}}, sqx_q} + {{(NormW-SqW){1'b0}}, sqy_q}
         + {{(NormW-SqW){1'b0}}, sqz_q};
    room = (cnt_q < CntW'(MaxSamples));
    nx.sum_x    = sum_x_q;
    nx.sum_y    = sum_y_q;
    nx.sum_z    = sum_z_q;
    nx.max_sq   = max_q;
    nx.count    = cnt_q;
    nx.too_many = tm_q;
    if (room) begin
      nx.sum_x = ax[SumW] ? '1 : ax[SumW-1:0];
      nx.sum_y = ay[SumW] ? '1 : ay[SumW-1:0];
      nx.sum_z = az[SumW] ? '1 : az[SumW-1:0];
      nx.max_sq = (norm > max_q) ? norm : max_q;
      nx.count  = cnt_q + CntW'(1);
    end else begin
      nx.too_many = 1'b1;
    end
  end

  assign q_push_o = s1_adv && s1_last_q;
  assign q_data_o = nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_z_q    <= '0;
      max_q      <= '0;
      cnt_q      <= '0;
      tm_q       <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last_q) begin
          sum_x_q <= '0;
          sum_y_q <= '0;
          sum_z_q <= '0;
          max_q   <= '0;
          cnt_q   <= '0;
          tm_q    <= 1'b0;
        end else begin
          sum_x_q <= nx.sum_x;
          sum_y_q <= nx.sum_y;
          sum_z_q <= nx.sum_z;
          max_q   <= nx.max_sq;
          cnt_q   <= nx.count;
          tm_q    <= nx.too_many;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sqx_q     <= px[SqW-1:0];
      sqy_q     <= py[SqW-1:0];
      sqz_q     <= pz[SqW-1:0];
      s1_last_q <= in_data_i.last;
    end
  end

endmodule

`default_nettype wire

### design/trmse_back.sv
// ----------------------------------------------------------------------------
// trmse_back
// Sequencer that turns one snapshot into a result: serial divide by the
// count, serial square roots and the total norm, then a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trmse_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire trmse_pkg::q_stat_t q_stat_i,
  input  wire trmse_pkg::snap_t   q_data_i,
  output logic                    q_pop_o,
  output logic                    empty,
  input  wire logic               pop,
  output trmse_pkg::out_item_t    res_o
);

  localparam int unsigned SumW  = trmse_pkg::SumW;
  localparam int unsigned CntW  = trmse_pkg::CntW;
  localparam int unsigned RootW = trmse_pkg::RootW;
  localparam int unsigned SremW = trmse_pkg::SremW;
  localparam int unsigned IterW = trmse_pkg::IterW;
  localparam int unsigned AccW  = trmse_pkg::AccW;
  localparam int unsigned RmseW = trmse_pkg::RmseW;
  localparam int unsigned TotW  = trmse_pkg::TotW;
  localparam int unsigned NormW = trmse_pkg::NormW;

  trmse_pkg::back_state_e state_q, state_d;
  trmse_pkg::snap_t       snap_q;
  logic [1:0]             axis_q;
  logic [IterW-1:0]       cnt_q;
  logic [SumW-1:0]        dvd_q;
  logic [CntW-1:0]        drem_q;
  logic [SumW-1:0]        srad_q;
  logic [SremW-1:0]       srem_q;
  logic [RootW-1:0]       sroot_q;
  logic [RmseW-1:0]       rootax_q [3];
  logic [2*RmseW-1:0]     prod_q;
  logic [AccW-1:0]        tot_q;
  logic [TotW-1:0]        total_q;
  logic [TotW-1:0]        maxr_q;
  logic                   res_valid_q;
  trmse_pkg::out_item_t   res_q;

  logic [CntW-1:0]        n_eff;
  logic [CntW:0]          rsh, rdif;
  logic                   dge;
  logic [CntW-1:0]        drem_nx;
  logic [SumW-1:0]        dvd_nx;
  logic [SremW+1:0]       rem2, trial, sdif;
  logic                   sge;
  logic [SremW-1:0]       srem_nx;
  logic [RootW-1:0]       sroot_nx;
  logic [AccW-1:0]        tot_nx;
  logic [SumW-1:0]        sum_next;
  logic                   div_done, sqrt_done, out_free;
  logic [RmseW-1:0]       root_sel;

  assign n_eff     = (snap_q.count == '0) ? CntW'(1) : snap_q.count;
  assign div_done  = (cnt_q == IterW'(SumW - 1));
  assign sqrt_done = (cnt_q == IterW'(RootW - 1));
  assign out_free  = !res_valid_q || pop;
  assign root_sel  = rootax_q[axis_q];

  always_comb begin
    rsh      = {drem_q, dvd_q[SumW-1]};
    rdif     = rsh - {1'b0, n_eff};
    dge      = (rsh >= {1'b0, n_eff});
    drem_nx  = dge ? rdif[CntW-1:0] : rsh[CntW-1:0];
    dvd_nx   = {dvd_q[SumW-2:0], dge};
    rem2     = {srem_q, srad_q[SumW-1:SumW-2]};
    trial    = {2'b00, sroot_q, 2'b01};
    sdif     = rem2 - trial;
    sge      = (rem2 >= trial);
    srem_nx  = sge ? sdif[SremW-1:0] : rem2[SremW-1:0];
    sroot_nx = {sroot_q[RootW-2:0], sge};
    tot_nx   = tot_q + AccW'(prod_q);
    case (axis_q)
      2'd0:    sum_next = snap_q.sum_y;
      default: sum_next = snap_q.sum_z;
    endcase
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      trmse_pkg::BkIdle: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          state_d = trmse_pkg::BkDiv;
        end
      end
      trmse_pkg::BkDiv:     if (div_done) state_d = trmse_pkg::BkSqrtAx;
      trmse_pkg::BkSqrtAx:  if (sqrt_done) state_d = trmse_pkg::BkMul;
      trmse_pkg::BkMul:     state_d = trmse_pkg::BkAcc;
      trmse_pkg::BkAcc: begin
        state_d = (axis_q == 2'd2) ? trmse_pkg::BkSqrtTot : trmse_pkg::BkDiv;
      end
      trmse_pkg::BkSqrtTot: if (sqrt_done) state_d = trmse_pkg::BkSqrtMax;
      trmse_pkg::BkSqrtMax: if (sqrt_done) state_d = trmse_pkg::BkOut;
      trmse_pkg::BkOut:     if (out_free) state_d = trmse_pkg::BkIdle;
      default:              state_d = trmse_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trmse_pkg::BkIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == trmse_pkg::BkOut && out_free) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      trmse_pkg::BkIdle: begin
        snap_q <= q_data_i;
        dvd_q  <= q_data_i.sum_x;
        drem_q <= '0;
        cnt_q  <= '0;
        axis_q <= 2'd0;
        tot_q  <= '0;
      end
      trmse_pkg::BkDiv: begin
        dvd_q  <= dvd_nx;
        drem_q <= drem_nx;
        if (div_done) begin
          cnt_q   <= '0;
          srad_q  <= dvd_nx;
          srem_q  <= '0;
          sroot_q <= '0;
        end else begin
          cnt_q <= cnt_q + IterW'(1);
        end
      end
      trmse_pkg::BkSqrtAx, trmse_pkg::BkSqrtTot, trmse_pkg::BkSqrtMax: begin
        if (sqrt_done) begin
          cnt_q   <= '0;
          srem_q  <= '0;
          sroot_q <= '0;
          if (state_q == trmse_pkg::BkSqrtAx) begin
            rootax_q[axis_q] <= sroot_nx[RmseW-1:0];
          end else if (state_q == trmse_pkg::BkSqrtTot) begin
            total_q <= sroot_nx[TotW-1:0];
            srad_q  <= {{(SumW-NormW){1'b0}}, snap_q.max_sq};
          end else begin
            maxr_q <= sroot_nx[TotW-1:0];
          end
        end else begin
          srad_q  <= {srad_q[SumW-3:0], 2'b00};
          srem_q  <= srem_nx;
          sroot_q <= sroot_nx;
          cnt_q   <= cnt_q + IterW'(1);
        end
      end
      trmse_pkg::BkMul: begin
        prod_q <= root_sel * root_sel;
      end
      trmse_pkg::BkAcc: begin
        tot_q <= tot_nx;
        if (axis_q == 2'd2) begin
          srad_q  <= {{(SumW-AccW){1'b0}}, tot_nx};
          srem_q  <= '0;
          sroot_q <= '0;
          cnt_q   <= '0;
        end else begin
          axis_q <= axis_q + 2'd1;
          dvd_q  <= sum_next;
          drem_q <= '0;
          cnt_q  <= '0;
        end
      end
      trmse_pkg::BkOut: begin
        if (out_free) begin
          res_q.rmse_x       <= rootax_q[0];
          res_q.rmse_y       <= rootax_q[1];
          res_q.rmse_z       <= rootax_q[2];
          res_q.rmse_total   <= total_q;
          res_q.max_dist     <= maxr_q;
          res_q.sample_count <= snap_q.count[trmse_pkg::OutCntW-1:0];
          res_q.overflow     <= snap_q.too_many;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty = !res_valid_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

### design/trajectory_rmse_max_error_core.sv
// ----------------------------------------------------------------------------
// trajectory_rmse_max_error_core
// Position error statistics between a reference and a replayed trajectory.
//
// Input channel: a queue port. One pair of 3D positions transfers at each
// edge with push high and full low; one pair a cycle is sustained while the
// snapshot queue has room. The pair marked last closes the trajectory.
// Result channel: a queue port. The result is on res_o while empty is low
// and transfers at an edge with pop high.
// Path to a result: the last pair enters the queue, the back fetches it,
// runs three serial divides of the 64-bit sums by the count, five square
// roots, squaring and accumulation per axis, then loads the result
// register and empty falls; the back sequencer takes a new trajectory only
// after it has loaded the result of the last one.
// The queue holds two finished trajectories while the back is busy or the
// receiver stalls; once it is full, full rises when the next last pair
// reaches the accumulator and holds until the queue frees a slot.
// Reset clears all sums, counts and pending results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trajectory_rmse_max_error_core_macros.svh"

module trajectory_rmse_max_error_core #(
  parameter int unsigned MaxSamples = trmse_pkg::MaxSamplesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire trmse_pkg::in_item_t in_data_i,
  output logic                     empty,
  input  wire logic                pop,
  output trmse_pkg::out_item_t     res_o
);

  localparam logic [trmse_pkg::OutCntW-1:0] OvfCount = trmse_pkg::OutCntW'(MaxSamples);

  trmse_pkg::q_stat_t q_stat;
  trmse_pkg::snap_t   q_in, q_out;
  logic               q_push, q_pop;

  trmse_front #(
    .MaxSamples(MaxSamples)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_data_i(in_data_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  trmse_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(q_in),
    .pop_i (q_pop),
    .data_o(q_out),
    .stat_o(q_stat)
  );

  trmse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_stat_i(q_stat),
    .q_data_i(q_out),
    .q_pop_o (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res_o   (res_o)
  );

  `TRMSE_ASSERT_IMP(a_total_le_max, !empty, res_o.rmse_total <= res_o.max_dist, "total above max")
  `TRMSE_ASSERT_IMP(a_axis_le_max, !empty, res_o.rmse_x <= res_o.max_dist, "axis above max")
  `TRMSE_ASSERT_IMP(a_ovf, !empty && res_o.overflow, res_o.sample_count == OvfCount, "bad count")
  `TRMSE_ASSERT(a_no_push_full, !(q_push && q_stat.full), "snapshot queue overrun")

endmodule

`default_nettype wire
